// ----- sv/button_chord_debouncer_macros.svh -----
// Assertion macros for the button chord debouncer.
// Used by the top level only; expects a clock named i_clk and reset i_rst_n in scope.
`ifndef BUTTON_CHORD_DEBOUNCER_MACROS_SVH
`define BUTTON_CHORD_DEBOUNCER_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define BCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define BCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/bcd_pkg.sv -----
// Package for the button chord debouncer: sizes, register indexes and request layouts.
// No dependencies.
`default_nettype none

package bcd_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int LEVEL_W      = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 16;

    // Buttons are handled on a vector at least as wide as the level field.
    localparam int PAD_W = (BUTTON_COUNT > LEVEL_W) ? BUTTON_COUNT : LEVEL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TIME   = 2'd0,
        REG_CHORD_WAIT_TIME = 2'd1,
        REG_INPUT_DISABLED  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]        pad;
        logic              mute_level;
        logic [LEVEL_W-1:0] button_levels;
        logic [TIME_W-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         pad;
        logic               muted;
        logic [LEVEL_W-1:0] sampled_buttons;
        logic [LEVEL_W-1:0] chord_value;
        logic               chord_valid;
    } t_out_item;

endpackage

`default_nettype wire

// ----- sv/button_chord_debouncer.sv -----
// Button chord debouncer top level: input request register, debounce and chord logic,
// result register. Depends on bcd_pkg and button_chord_debouncer_macros.svh.
//
//   channel   | direction | payload (lowest bit first)
//   s_axis    | in        | time_now[31:0], button_levels[3:0], mute_level, zero pad to 40
//   m_axis    | out       | chord_valid, chord_value[3:0], sampled_buttons[3:0], muted, pad
//   cfg write | in        | i_cfg_idx selects debounce, chord wait or disable register
//
// Each request passes through the input and then the result register; a new request can
// be taken every cycle unless the result register stalls. All per-button time checks are
// 32-bit subtract and compare units running in parallel, which sets the cycle time.
// Reset is synchronous and active low, and clears all timing state to zero.
// When the result register is stalled, the input register holds one more request.
`default_nettype none
`include "button_chord_debouncer_macros.svh"

module button_chord_debouncer
    import bcd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // Poll requests.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: time_now[31:0], button_levels[35:32], mute_level[36], zero [39:37]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result requests.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: chord_valid[0], chord_value[4:1], sampled_buttons[8:5], muted[9], zero [15:10]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // Configuration registers.
    logic [CFG_W-1:0] r_debounce_time;
    logic [CFG_W-1:0] r_chord_wait_time;
    logic             r_input_disabled;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Debounce and chord state.
    logic [PAD_W-1:0]  r_button_state;
    logic [TIME_W-1:0] r_button_change_time [BUTTON_COUNT];
    logic              r_chord_open;
    logic [TIME_W-1:0] r_chord_start_time;
    logic [LEVEL_W-1:0] r_chord_bits;
    logic [TIME_W-1:0] r_mute_sample_time;
    logic              r_mute_held;

    // Next-state values.
    logic [PAD_W-1:0]  n_button_state;
    logic [TIME_W-1:0] n_button_change_time [BUTTON_COUNT];
    logic              n_chord_open;
    logic [TIME_W-1:0] n_chord_start_time;
    logic [LEVEL_W-1:0] n_chord_bits;
    logic [TIME_W-1:0] n_mute_sample_time;
    logic              n_mute_held;
    t_out_item         n_out;

    logic              w_process;
    logic [PAD_W-1:0]  w_levels;
    logic [PAD_W-1:0]  w_sampled;
    logic              w_new_press;
    logic [TIME_W-1:0] w_debounce;
    logic [TIME_W-1:0] w_chord_wait;

    // The input register advances whenever the result register is free or being drained.
    assign w_process     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_process;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign w_levels     = PAD_W'(r_in.button_levels);
    assign w_debounce   = TIME_W'(r_debounce_time);
    assign w_chord_wait = TIME_W'(r_chord_wait_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= CFG_W'(50);
            r_chord_wait_time <= CFG_W'(100);
            r_input_disabled  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data;
                REG_CHORD_WAIT_TIME: r_chord_wait_time <= i_cfg_data;
                REG_INPUT_DISABLED:  r_input_disabled  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_button_state = r_button_state;
        w_sampled      = '0;
        w_new_press    = 1'b0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_button_change_time[i] = r_button_change_time[i];
            // A button is looked at only once its lockout has run out.
            if ((r_in.time_now - r_button_change_time[i]) > w_debounce) begin
                if (r_button_state[i] != w_levels[i]) begin
                    n_button_change_time[i] = r_in.time_now;
                    if (w_levels[i]) begin
                        w_new_press = 1'b1;
                    end
                end
                n_button_state[i] = w_levels[i];
                w_sampled[i]      = w_levels[i];
            end
        end

        // The first new press while no chord is collecting opens a fresh window.
        n_chord_open       = r_chord_open;
        n_chord_start_time = r_chord_start_time;
        n_chord_bits       = r_chord_bits;
        if (!r_chord_open && w_new_press) begin
            n_chord_open       = 1'b1;
            n_chord_start_time = r_in.time_now;
            n_chord_bits       = '0;
        end

        n_out                 = '0;
        n_out.sampled_buttons = w_sampled[LEVEL_W-1:0];
        if (n_chord_open) begin
            n_chord_bits = n_chord_bits | w_sampled[LEVEL_W-1:0];
            if ((r_in.time_now - n_chord_start_time) > w_chord_wait) begin
                n_chord_open       = 1'b0;
                n_chord_start_time = r_in.time_now;
                n_out.chord_valid  = 1'b1;
                n_out.chord_value  = n_chord_bits;
            end
        end

        // Mute is resampled at most once per debounce period.
        n_mute_sample_time = r_mute_sample_time;
        n_mute_held        = r_mute_held;
        if ((r_in.time_now - r_mute_sample_time) > w_debounce) begin
            n_mute_sample_time = r_in.time_now;
            n_mute_held        = r_in.mute_level;
        end
        n_out.muted = n_mute_held;

        // While disabled, the result is all zero.
        if (r_input_disabled) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_process) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= t_in_item'(s_axis_tdata);
        end
        if (w_process) begin
            r_out <= n_out;
        end
    end

    // State only moves on a processed request while the block is enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_state     <= '0;
            r_chord_open       <= 1'b0;
            r_chord_start_time <= '0;
            r_chord_bits       <= '0;
            r_mute_sample_time <= '0;
            r_mute_held        <= 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_button_change_time[i] <= '0;
            end
        end else if (w_process && !r_input_disabled) begin
            r_button_state     <= n_button_state;
            r_chord_open       <= n_chord_open;
            r_chord_start_time <= n_chord_start_time;
            r_chord_bits       <= n_chord_bits;
            r_mute_sample_time <= n_mute_sample_time;
            r_mute_held        <= n_mute_held;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_button_change_time[i] <= n_button_change_time[i];
            end
        end
    end

    // A chord value only appears together with its valid flag.
    `BCD_ASSERT(a_chord_value_qualified, (r_out_valid && !r_out.chord_valid) |-> (r_out.chord_value == '0), "chord value without chord valid")
    // Disabled polls leave the chord and mute state untouched.
    `BCD_ASSERT(a_disabled_frozen, (w_process && r_input_disabled) |=> ($stable(r_chord_open) && $stable(r_mute_held) && $stable(r_chord_bits)), "state changed while disabled")
    // An empty result register never blocks the input side.
    `BCD_ASSERT(a_ready_when_empty, !r_out_valid |-> s_axis_tready, "input stalled with empty result register")
    // Reset empties both pipeline registers.
    `BCD_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for button_chord_debouncer: streams poll requests, predicts
// each result with a behavioral copy of the debounce and chord logic and compares them.
// Depends on bcd_pkg and the button_chord_debouncer RTL.

module tb;
    import bcd_pkg::*;

    // Index past the end of the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: time_now[31:0], button_levels[35:32], mute_level[36], zero [39:37]
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: chord_valid[0], chord_value[4:1], sampled_buttons[8:5], muted[9], zero [15:10]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    button_chord_debouncer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Results predicted for accepted poll requests, oldest first.
    t_out_item poll_results_due[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Idle rates in percent; the sender's is used by the stimulus process only.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // Long receiver hold-off: the stimulus bumps hold_req_id, the receiver process counts.
    int hold_req_id = 0;
    int hold_seen_id = 0;
    int hold_left = 0;

    // Behavioral copy of the block's registers and state.
    logic [CFG_W-1:0]  lockout_ms;
    logic [CFG_W-1:0]  chord_wait_ms;
    logic              polls_disabled;
    logic [PAD_W-1:0]  btn_level_q;
    logic [TIME_W-1:0] btn_change_ms [BUTTON_COUNT];
    logic              window_open;
    logic [TIME_W-1:0] window_start_ms;
    logic [LEVEL_W-1:0] window_bits;
    logic [TIME_W-1:0] mute_sample_ms;
    logic              mute_q;

    // Time base for the random polls, stepped forward or jumped by the polling task.
    logic [TIME_W-1:0] poll_clock_ms = '0;
    logic [LEVEL_W-1:0] held_buttons = '0;
    logic              held_mute = 1'b0;

    function automatic void clear_debounce_state();
        lockout_ms      = 16'd50;
        chord_wait_ms   = 16'd100;
        polls_disabled  = 1'b0;
        btn_level_q     = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) btn_change_ms[b] = '0;
        window_open     = 1'b0;
        window_start_ms = '0;
        window_bits     = '0;
        mute_sample_ms  = '0;
        mute_q          = 1'b0;
    endfunction

    // Works out the result of one poll and advances the debounce and chord state.
    function automatic t_out_item debounce_poll(input logic [TIME_W-1:0] now_ms,
                                                input logic [LEVEL_W-1:0] levels,
                                                input logic mute);
        t_out_item         res;
        logic [PAD_W-1:0]  sampled;
        logic [TIME_W-1:0] age;
        logic              active;
        res = '0;
        sampled = '0;
        if (polls_disabled) return res;

        for (int b = 0; b < BUTTON_COUNT; b++) begin
            // Buttons above the level field always read inactive.
            active = (b < LEVEL_W) ? levels[b] : 1'b0;
            age = now_ms - btn_change_ms[b];
            if (age > TIME_W'(lockout_ms)) begin
                if (btn_level_q[b] != active) begin
                    btn_change_ms[b] = now_ms;
                    // The first new press with no window open starts a fresh chord.
                    if (active && !window_open) begin
                        window_open     = 1'b1;
                        window_start_ms = now_ms;
                        window_bits     = '0;
                    end
                end
                btn_level_q[b] = active;
                sampled[b] = active;
            end
        end

        if (window_open) begin
            window_bits = window_bits | sampled[LEVEL_W-1:0];
            age = now_ms - window_start_ms;
            if (age > TIME_W'(chord_wait_ms)) begin
                // The window closes; its bits stay until the next window opens.
                window_open     = 1'b0;
                window_start_ms = now_ms;
                res.chord_valid = 1'b1;
                res.chord_value = window_bits;
            end
        end

        age = now_ms - mute_sample_ms;
        if (age > TIME_W'(lockout_ms)) begin
            mute_sample_ms = now_ms;
            mute_q = mute;
        end

        res.sampled_buttons = sampled[LEVEL_W-1:0];
        res.muted = mute_q;
        return res;
    endfunction

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a counted hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req_id != hold_seen_id) begin
            hold_seen_id  <= hold_req_id;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result checker: every accepted result request is matched with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_out_item'(m_axis_tdata);
            if (poll_results_due.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: valid=%0d chord=%h sampled=%h muted=%0d",
                             got.chord_valid, got.chord_value, got.sampled_buttons,
                             got.muted);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = poll_results_due.pop_front();
                if (got.chord_valid !== want.chord_valid ||
                    got.chord_value !== want.chord_value ||
                    got.sampled_buttons !== want.sampled_buttons ||
                    got.muted !== want.muted) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $write("result mismatch: expected valid=%0d chord=%h sampled=%h",
                               want.chord_valid, want.chord_value, want.sampled_buttons);
                        $display(" muted=%0d, got valid=%0d chord=%h sampled=%h muted=%0d",
                                 want.muted, got.chord_valid, got.chord_value,
                                 got.sampled_buttons, got.muted);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Offers one poll request and returns at the edge where it is taken. The valid
    // stays high afterwards, so back-to-back requests drop it only when the idle rate cuts in.
    task automatic send_poll(input logic [TIME_W-1:0] now_ms,
                             input logic [LEVEL_W-1:0] levels,
                             input logic mute);
        t_in_item req;
        req = '0;
        req.time_now      = now_ms;
        req.button_levels = levels;
        req.mute_level    = mute;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        poll_results_due.push_back(debounce_poll(now_ms, levels, mute));
    endtask

    // Stops offering requests and waits for every predicted result to come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (poll_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the block drained, so the prediction can
    // switch to the new value at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE_TIME:   lockout_ms = value;
            REG_CHORD_WAIT_TIME: chord_wait_ms = value;
            REG_INPUT_DISABLED:  polls_disabled = value[0];
            default: ;
        endcase
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    // Mostly plausible button activity on an advancing clock, with some noise polls
    // that jump anywhere in time and set any levels.
    task automatic run_random_polls(input int count);
        int unsigned step_max;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            step_max = (int'(lockout_ms) + int'(chord_wait_ms)) / 8 + 2;
            if (pick < 8) begin
                poll_clock_ms = $urandom();
                send_poll(poll_clock_ms, LEVEL_W'($urandom()), 1'($urandom()));
            end else begin
                if (pick < 13) poll_clock_ms = poll_clock_ms + $urandom_range(0, 32'h2_0000);
                else poll_clock_ms = poll_clock_ms + $urandom_range(0, step_max);
                if ($urandom_range(99) < 25)
                    held_buttons = held_buttons ^ LEVEL_W'($urandom_range(1, 15));
                if ($urandom_range(99) < 12) held_mute = !held_mute;
                send_poll(poll_clock_ms, held_buttons, held_mute);
            end
        end
    endtask

    // Reset values: nothing is sampled at time zero, then a full chord with mute.
    task automatic test_reset_defaults();
        send_poll(32'd0, 4'hF, 1'b1);
        send_poll(32'd51, 4'hF, 1'b1);
        send_poll(32'd120, 4'h0, 1'b0);
        send_poll(32'd152, 4'h5, 1'b0);
        send_poll(32'd300, 4'h0, 1'b1);
        send_poll(32'hFFFF_FFFF, 4'hA, 1'b0);
    endtask

    // Zero and full-scale lockout and chord times.
    task automatic test_register_extremes();
        write_reg(REG_DEBOUNCE_TIME, 16'd0);
        write_reg(REG_CHORD_WAIT_TIME, 16'd0);
        send_poll(32'd1000, 4'h3, 1'b1);
        send_poll(32'd1000, 4'hC, 1'b0);
        send_poll(32'd1001, 4'hC, 1'b0);
        send_poll(32'd1002, 4'h0, 1'b1);
        write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
        write_reg(REG_CHORD_WAIT_TIME, 16'hFFFF);
        send_poll(32'h0002_0000, 4'h9, 1'b1);
        send_poll(32'h0002_FFFF, 4'h6, 1'b0);
        send_poll(32'h0003_0000, 4'h6, 1'b0);
        send_poll(32'h0004_0001, 4'h0, 1'b0);
    endtask

    // Disabled polls give all-zero results and leave the state untouched.
    task automatic test_disable();
        write_reg(REG_INPUT_DISABLED, 16'd1);
        send_poll(32'h0010_0000, 4'hF, 1'b1);
        send_poll(32'h0020_0000, 4'h0, 1'b1);
        write_reg(REG_INPUT_DISABLED, 16'd0);
        send_poll(32'h0030_0000, 4'h0, 1'b0);
    endtask

    // A write to an index beyond the register list must change nothing.
    task automatic test_unused_index();
        write_reg(REG_NONE, 16'hFFFF);
        send_poll(32'h0031_0000, 4'hF, 1'b1);
        send_poll(32'h0031_0001, 4'h0, 1'b0);
    endtask

    // Lockout and chord windows that straddle the 32-bit time wrap.
    task automatic test_time_wrap();
        write_reg(REG_DEBOUNCE_TIME, 16'd50);
        write_reg(REG_CHORD_WAIT_TIME, 16'd100);
        send_poll(32'hFFFF_FFC0, 4'h3, 1'b1);
        send_poll(32'h0000_0010, 4'h7, 1'b0);
        send_poll(32'h0000_0040, 4'h0, 1'b0);
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the block
    // fills and stalls its input; then the sender pauses until everything is back.
    task automatic test_backpressure();
        write_reg(REG_DEBOUNCE_TIME, 16'd20);
        write_reg(REG_CHORD_WAIT_TIME, 16'd40);
        set_idling(0, 0);
        hold_req_id <= hold_req_id + 1;
        run_random_polls(40);
        wait_for_results();
    endtask

    // Random polls under each idling mix; phases after the first get fresh register values.
    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(54, 0);
                2: set_idling(0, 54);
                default: set_idling(8, 8);
            endcase
            write_reg(REG_DEBOUNCE_TIME, (phase == 0) ? 16'd50 : CFG_W'($urandom_range(0, 80)));
            write_reg(REG_CHORD_WAIT_TIME,
                      (phase == 0) ? 16'd100 : CFG_W'($urandom_range(0, 200)));
            // One phase runs its clock through the 32-bit wrap.
            if (phase == 2) poll_clock_ms = 32'hFFFF_F000;
            run_random_polls(310);
        end
        // A short stretch with the input gated off, then back on.
        write_reg(REG_INPUT_DISABLED, 16'd1);
        run_random_polls(20);
        write_reg(REG_INPUT_DISABLED, 16'd0);
        run_random_polls(20);
    endtask

    initial begin
        clear_debounce_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_disable();
        test_unused_index();
        test_time_wrap();
        test_random_phases();
        test_backpressure();

        set_idling(0, 0);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && poll_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
